### hdl/d2q9me_pkg.sv
// ----------------------------------------------------------------------------
// d2q9me_pkg
// shared types, constants and fixed-point helpers for the d2q9 moments and
// equilibrium pipeline
// ----------------------------------------------------------------------------
package d2q9me_pkg;

    localparam int FRAC_BITS     = 24;
    localparam int DATA_WIDTH    = 32;
    localparam int PROD_WIDTH    = 2 * DATA_WIDTH;
    localparam int SUM_WIDTH     = DATA_WIDTH + 4;
    localparam int NUM_DIR       = 9;
    localparam int DIR_WIDTH     = 4;
    localparam int REG_IDX_WIDTH = 3;

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef logic signed [PROD_WIDTH-1:0] prod_t;
    typedef logic signed [SUM_WIDTH-1:0]  sum_t;
    typedef logic [DIR_WIDTH-1:0]         dir_t;

    // lattice directions
    localparam dir_t DIR_REST = 4'd0;
    localparam dir_t DIR_E    = 4'd1;
    localparam dir_t DIR_NE   = 4'd2;
    localparam dir_t DIR_N    = 4'd3;
    localparam dir_t DIR_NW   = 4'd4;
    localparam dir_t DIR_W    = 4'd5;
    localparam dir_t DIR_SW   = 4'd6;
    localparam dir_t DIR_S    = 4'd7;
    localparam dir_t DIR_SE   = 4'd8;
    localparam dir_t DIR_LAST = DIR_SE;

    // configuration register indexes
    typedef enum logic [REG_IDX_WIDTH-1:0] {
        REG_XI_SCALE       = 3'd0,
        REG_RHO_REF        = 3'd1,
        REG_INV_RHO_REF    = 3'd2,
        REG_INV_RT         = 3'd3,
        REG_LAMBDA_REF     = 3'd4,
        REG_INV_LAMBDA_REF = 3'd5,
        REG_TIME_STEP      = 3'd6
    } reg_idx_t;

    localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    function automatic word_t sat_const(input longint v);
        if (v > longint'(WORD_MAX)) begin
            return WORD_MAX;
        end
        return word_t'(v);
    endfunction

    localparam longint ONE_Q = longint'(1) <<< FRAC_BITS;

    localparam word_t HALF_Q = sat_const((ONE_Q + 1) / 2);
    localparam word_t W_REST = sat_const((4 * ONE_Q + 4) / 9);
    localparam word_t W_AXIS = sat_const((ONE_Q + 4) / 9);
    localparam word_t W_DIAG = sat_const((ONE_Q + 18) / 36);

    typedef struct packed {
        word_t xi_scale;
        word_t rho_ref;
        word_t inv_rho_ref;
        word_t inv_rt;
        word_t lambda_ref;
        word_t inv_lambda_ref;
        word_t time_step;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        xi_scale:       sat_const(ONE_Q),
        rho_ref:        sat_const(ONE_Q),
        inv_rho_ref:    sat_const(ONE_Q),
        inv_rt:         sat_const(3 * ONE_Q),
        lambda_ref:     sat_const((3 * ONE_Q + 1) / 2),
        inv_lambda_ref: sat_const((2 * ONE_Q + 1) / 3),
        time_step:      sat_const(ONE_Q)
    };

    typedef struct packed {
        word_t [NUM_DIR-1:0] pops;
        word_t               force_x;
        word_t               force_y;
        logic                face;
    } item_t;

    typedef struct packed {
        dir_t dir;
        logic last;
    } tag_t;

    typedef struct packed {
        logic  valid;
        tag_t  tag;
        item_t item;
    } beat_t;

    typedef struct packed {
        logic  valid;
        tag_t  tag;
        word_t rho;
        word_t ux;
        word_t uy;
        word_t pres;
    } mom_t;

    typedef struct packed {
        dir_t  dir;
        word_t equilibrium;
        word_t density;
        word_t velocity_x;
        word_t velocity_y;
        word_t pressure;
        logic  last;
    } res_t;

    // sign extension into the sum width
    function automatic sum_t ext(input word_t w);
        return sum_t'(w);
    endfunction

    function automatic word_t sat_sum(input sum_t v);
        logic [SUM_WIDTH-DATA_WIDTH:0] hi;
        hi = v[SUM_WIDTH-1:DATA_WIDTH-1];
        if (&hi || ~|hi) begin
            return word_t'(v[DATA_WIDTH-1:0]);
        end
        return v[SUM_WIDTH-1] ? WORD_MIN : WORD_MAX;
    endfunction

    // full signed product of two words
    function automatic prod_t mul(input word_t a, input word_t b);
        return prod_t'(a) * prod_t'(b);
    endfunction

    // round magnitude to nearest (ties away from zero) and saturate
    function automatic word_t rnd_sat(input prod_t p);
        logic                  neg;
        logic [PROD_WIDTH-1:0] mag;
        logic [PROD_WIDTH-1:0] rnd;
        logic [PROD_WIDTH-1:0] max_mag;
        neg     = p[PROD_WIDTH-1];
        mag     = neg ? PROD_WIDTH'(-p) : PROD_WIDTH'(p);
        rnd     = (mag + (PROD_WIDTH'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        max_mag = (PROD_WIDTH'(1) << (DATA_WIDTH - 1)) - PROD_WIDTH'(!neg);
        if (rnd > max_mag) begin
            rnd = max_mag;
        end
        return neg ? word_t'(DATA_WIDTH'(-rnd)) : word_t'(DATA_WIDTH'(rnd));
    endfunction

endpackage

### hdl/d2q9me_feed.sv
// ----------------------------------------------------------------------------
// d2q9me_feed
// input holding register and direction sequencer: one beat per direction
// ----------------------------------------------------------------------------
module d2q9me_feed (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    output logic              in_ready,
    input  d2q9me_pkg::item_t item,
    output d2q9me_pkg::beat_t beat
);
    import d2q9me_pkg::*;

    logic  hold_valid_reg;
    dir_t  dir_reg;
    item_t item_reg;
    logic  step_last;
    logic  take;

    assign step_last = (dir_reg == DIR_LAST);
    assign in_ready  = !hold_valid_reg || (en && step_last);
    assign take      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            dir_reg        <= DIR_REST;
        end
        else if (take)
        begin
            hold_valid_reg <= 1'b1;
            dir_reg        <= DIR_REST;
        end
        else if (en && hold_valid_reg)
        begin
            if (step_last)
            begin
                hold_valid_reg <= 1'b0;
                dir_reg        <= DIR_REST;
            end
            else
            begin
                dir_reg <= dir_reg + DIR_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
    end

    assign beat.valid    = hold_valid_reg;
    assign beat.tag.dir  = dir_reg;
    assign beat.tag.last = step_last;
    assign beat.item     = item_reg;

endmodule

### hdl/d2q9me_moments.sv
// ----------------------------------------------------------------------------
// d2q9me_moments
// density, velocity and pressure pipeline, seven register stages
// ----------------------------------------------------------------------------
module d2q9me_moments (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  d2q9me_pkg::cfg_t  cfg,
    input  d2q9me_pkg::beat_t beat,
    output d2q9me_pkg::mom_t  mom
);
    import d2q9me_pkg::*;

    localparam int MOM_STAGES = 7;

    logic [MOM_STAGES-1:0] vld_reg;
    tag_t                  tag_reg [MOM_STAGES];

    // stage 1: raw sums and force products
    logic  s1_face_reg;
    sum_t  s1_rho_reg, s1_sx_reg, s1_sy_reg;
    prod_t s1_pfx_reg, s1_pfy_reg;
    // stage 2: saturated moments and force
    logic  s2_face_reg;
    word_t s2_rho_reg, s2_sx_reg, s2_sy_reg, s2_fx_reg, s2_fy_reg;
    // stage 3
    logic  s3_face_reg;
    word_t s3_rho_reg, s3_dr_reg, s3_fx_reg, s3_fy_reg;
    prod_t s3_pxs_reg, s3_pys_reg, s3_hfx_reg, s3_hfy_reg;
    // stage 4
    word_t s4_rho_reg, s4_mx_reg, s4_my_reg, s4_fx_reg, s4_fy_reg;
    prod_t s4_pp_reg;
    // stage 5
    word_t s5_rho_reg, s5_vx_reg, s5_vy_reg, s5_pr_reg;
    // stage 6
    word_t s6_rho_reg;
    prod_t s6_ux_reg, s6_uy_reg, s6_pr_reg;
    // stage 7
    word_t s7_rho_reg, s7_ux_reg, s7_uy_reg, s7_pr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[MOM_STAGES-2:0], beat.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= beat.tag;
            for (int k = 1; k < MOM_STAGES; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end

            s1_face_reg <= beat.item.face;
            s1_rho_reg  <= ext(beat.item.pops[0]) + ext(beat.item.pops[1])
                         + ext(beat.item.pops[2]) + ext(beat.item.pops[3])
                         + ext(beat.item.pops[4]) + ext(beat.item.pops[5])
                         + ext(beat.item.pops[6]) + ext(beat.item.pops[7])
                         + ext(beat.item.pops[8]);
            s1_sx_reg   <= ext(beat.item.pops[1]) + ext(beat.item.pops[2])
                         + ext(beat.item.pops[8]) - ext(beat.item.pops[4])
                         - ext(beat.item.pops[5]) - ext(beat.item.pops[6]);
            s1_sy_reg   <= ext(beat.item.pops[2]) + ext(beat.item.pops[3])
                         + ext(beat.item.pops[4]) - ext(beat.item.pops[6])
                         - ext(beat.item.pops[7]) - ext(beat.item.pops[8]);
            s1_pfx_reg  <= mul(cfg.time_step, beat.item.force_x);
            s1_pfy_reg  <= mul(cfg.time_step, beat.item.force_y);

            s2_face_reg <= s1_face_reg;
            s2_rho_reg  <= sat_sum(s1_rho_reg);
            s2_sx_reg   <= sat_sum(s1_sx_reg);
            s2_sy_reg   <= sat_sum(s1_sy_reg);
            s2_fx_reg   <= rnd_sat(s1_pfx_reg);
            s2_fy_reg   <= rnd_sat(s1_pfy_reg);

            s3_face_reg <= s2_face_reg;
            s3_rho_reg  <= s2_rho_reg;
            s3_dr_reg   <= sat_sum(ext(s2_rho_reg) - ext(cfg.rho_ref));
            s3_pxs_reg  <= mul(cfg.xi_scale, s2_sx_reg);
            s3_pys_reg  <= mul(cfg.xi_scale, s2_sy_reg);
            s3_hfx_reg  <= mul(s2_fx_reg, HALF_Q);
            s3_hfy_reg  <= mul(s2_fy_reg, HALF_Q);
            s3_fx_reg   <= s2_fx_reg;
            s3_fy_reg   <= s2_fy_reg;

            // faces take half the force step
            s4_rho_reg  <= s3_rho_reg;
            s4_mx_reg   <= rnd_sat(s3_pxs_reg);
            s4_my_reg   <= rnd_sat(s3_pys_reg);
            s4_fx_reg   <= s3_face_reg ? rnd_sat(s3_hfx_reg) : s3_fx_reg;
            s4_fy_reg   <= s3_face_reg ? rnd_sat(s3_hfy_reg) : s3_fy_reg;
            s4_pp_reg   <= mul(HALF_Q, s3_dr_reg);

            s5_rho_reg  <= s4_rho_reg;
            s5_vx_reg   <= sat_sum(ext(s4_mx_reg) + ext(s4_fx_reg));
            s5_vy_reg   <= sat_sum(ext(s4_my_reg) + ext(s4_fy_reg));
            s5_pr_reg   <= rnd_sat(s4_pp_reg);

            s6_rho_reg  <= s5_rho_reg;
            s6_ux_reg   <= mul(s5_vx_reg, cfg.inv_rho_ref);
            s6_uy_reg   <= mul(s5_vy_reg, cfg.inv_rho_ref);
            s6_pr_reg   <= mul(s5_pr_reg, cfg.inv_lambda_ref);

            s7_rho_reg  <= s6_rho_reg;
            s7_ux_reg   <= rnd_sat(s6_ux_reg);
            s7_uy_reg   <= rnd_sat(s6_uy_reg);
            s7_pr_reg   <= rnd_sat(s6_pr_reg);
        end
    end

    assign mom.valid = vld_reg[MOM_STAGES-1];
    assign mom.tag   = tag_reg[MOM_STAGES-1];
    assign mom.rho   = s7_rho_reg;
    assign mom.ux    = s7_ux_reg;
    assign mom.uy    = s7_uy_reg;
    assign mom.pres  = s7_pr_reg;

endmodule

### hdl/d2q9me_equil.sv
// ----------------------------------------------------------------------------
// d2q9me_equil
// per-direction equilibrium pipeline, twelve stages plus the output register
// ----------------------------------------------------------------------------
module d2q9me_equil (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  d2q9me_pkg::cfg_t cfg,
    input  d2q9me_pkg::mom_t mom,
    output logic             out_valid,
    output d2q9me_pkg::res_t res
);
    import d2q9me_pkg::*;

    localparam int EQ_STAGES = 12;

    // projection of the velocity on the lattice direction
    function automatic word_t dir_proj(input dir_t d, input word_t ux, input word_t uy);
        sum_t e;
        unique case (d)
            DIR_REST: e = '0;
            DIR_E:    e = ext(ux);
            DIR_NE:   e = ext(ux) + ext(uy);
            DIR_N:    e = ext(uy);
            DIR_NW:   e = ext(uy) - ext(ux);
            DIR_W:    e = -ext(ux);
            DIR_SW:   e = -ext(ux) - ext(uy);
            DIR_S:    e = -ext(uy);
            DIR_SE:   e = ext(ux) - ext(uy);
            default:  e = '0;
        endcase
        return sat_sum(e);
    endfunction

    function automatic word_t dir_weight(input dir_t d);
        word_t w;
        unique case (d)
            DIR_REST:                    w = W_REST;
            DIR_E, DIR_N, DIR_W, DIR_S:  w = W_AXIS;
            DIR_NE, DIR_NW, DIR_SW, DIR_SE: w = W_DIAG;
            default:                     w = '0;
        endcase
        return w;
    endfunction

    logic [EQ_STAGES-1:0] vld_reg;
    mom_t                 m_reg [EQ_STAGES];

    prod_t e1_uxx_reg, e1_uyy_reg;
    word_t e1_e_reg;
    word_t e2_uxx_reg, e2_uyy_reg;
    prod_t e2_xe_reg;
    word_t e3_uu_reg, e3_xe_reg;
    prod_t e4_u1_reg, e4_uul_reg;
    word_t e5_u1_reg, e5_uul_reg;
    word_t e6_u1_reg, e6_uul_reg;
    prod_t e6_sq_reg;
    word_t e7_u1_reg, e7_uul_reg, e7_sq_reg;
    word_t e8_u1_reg, e8_uul_reg;
    prod_t e8_hsq_reg;
    word_t e9_q_reg;
    prod_t e10_rq_reg;
    word_t e11_t_reg;
    prod_t e12_wt_reg;

    logic  out_valid_reg;
    res_t  res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[EQ_STAGES-2:0], mom.valid};
            out_valid_reg <= vld_reg[EQ_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= mom;
            for (int k = 1; k < EQ_STAGES; k++)
            begin
                m_reg[k] <= m_reg[k-1];
            end

            e1_uxx_reg <= mul(mom.ux, mom.ux);
            e1_uyy_reg <= mul(mom.uy, mom.uy);
            e1_e_reg   <= dir_proj(mom.tag.dir, mom.ux, mom.uy);

            e2_uxx_reg <= rnd_sat(e1_uxx_reg);
            e2_uyy_reg <= rnd_sat(e1_uyy_reg);
            e2_xe_reg  <= mul(cfg.xi_scale, e1_e_reg);

            e3_uu_reg  <= sat_sum(ext(e2_uxx_reg) + ext(e2_uyy_reg));
            e3_xe_reg  <= rnd_sat(e2_xe_reg);

            e4_u1_reg  <= mul(e3_xe_reg, cfg.inv_rt);
            e4_uul_reg <= mul(e3_uu_reg, cfg.lambda_ref);

            e5_u1_reg  <= rnd_sat(e4_u1_reg);
            e5_uul_reg <= rnd_sat(e4_uul_reg);

            e6_u1_reg  <= e5_u1_reg;
            e6_uul_reg <= e5_uul_reg;
            e6_sq_reg  <= mul(e5_u1_reg, e5_u1_reg);

            e7_u1_reg  <= e6_u1_reg;
            e7_uul_reg <= e6_uul_reg;
            e7_sq_reg  <= rnd_sat(e6_sq_reg);

            e8_u1_reg  <= e7_u1_reg;
            e8_uul_reg <= e7_uul_reg;
            e8_hsq_reg <= mul(HALF_Q, e7_sq_reg);

            // u1 + u1^2/2 - uu*lambda, with the sum saturated at the end
            e9_q_reg   <= sat_sum(ext(e8_u1_reg) + ext(rnd_sat(e8_hsq_reg))
                                  - ext(e8_uul_reg));

            e10_rq_reg <= mul(cfg.rho_ref, e9_q_reg);

            // m_reg[k] travels alongside stage k+1
            e11_t_reg  <= sat_sum(ext(m_reg[9].rho) + ext(rnd_sat(e10_rq_reg)));

            e12_wt_reg <= mul(dir_weight(m_reg[10].tag.dir), e11_t_reg);

            res_reg.dir         <= m_reg[EQ_STAGES-1].tag.dir;
            res_reg.last        <= m_reg[EQ_STAGES-1].tag.last;
            res_reg.equilibrium <= rnd_sat(e12_wt_reg);
            res_reg.density     <= m_reg[EQ_STAGES-1].rho;
            res_reg.velocity_x  <= m_reg[EQ_STAGES-1].ux;
            res_reg.velocity_y  <= m_reg[EQ_STAGES-1].uy;
            res_reg.pressure    <= m_reg[EQ_STAGES-1].pres;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

### hdl/d2q9_moments_and_equilibrium.sv
// ----------------------------------------------------------------------------
// d2q9_moments_and_equilibrium
// d2q9 lattice moments (density, velocity, pressure) and the nine
// incompressible equilibrium values of one cell or face, signed Q8.24
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   ------------------------------------------
//  in        in_valid / in_ready    dist_0..dist_8, force_x, force_y, req_type
//  out       out_valid / out_ready  direction, equilibrium, density,
//                                   velocity_x, velocity_y, pressure, last
//  cfg       cfg_wr_en              cfg_index, cfg_data (no read-back)
//
//  each input beat gives nine output beats, directions 0 to 8 in order, and
//  the holding register keeps an item until its ninth beat is issued, so no new
//  item enters before then; the next item is taken on the cycle of the ninth beat
//  each beat passes the holding register, moment stages, equilibrium stages, output register
//  reset clears every valid bit and loads the registers with their defaults
//  a stalled output freezes the whole pipeline in place; nothing is dropped
//
module d2q9_moments_and_equilibrium (
    input  logic                                       clk,
    input  logic                                       rst_n,
    // input channel
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  d2q9me_pkg::word_t                          dist_0,
    input  d2q9me_pkg::word_t                          dist_1,
    input  d2q9me_pkg::word_t                          dist_2,
    input  d2q9me_pkg::word_t                          dist_3,
    input  d2q9me_pkg::word_t                          dist_4,
    input  d2q9me_pkg::word_t                          dist_5,
    input  d2q9me_pkg::word_t                          dist_6,
    input  d2q9me_pkg::word_t                          dist_7,
    input  d2q9me_pkg::word_t                          dist_8,
    input  d2q9me_pkg::word_t                          force_x,
    input  d2q9me_pkg::word_t                          force_y,
    input  logic                                       req_type,
    // output channel
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output d2q9me_pkg::dir_t                           direction,
    output d2q9me_pkg::word_t                          equilibrium,
    output d2q9me_pkg::word_t                          density,
    output d2q9me_pkg::word_t                          velocity_x,
    output d2q9me_pkg::word_t                          velocity_y,
    output d2q9me_pkg::word_t                          pressure,
    output logic                                       last,
    // configuration write port
    input  logic                                       cfg_wr_en,
    input  logic [d2q9me_pkg::REG_IDX_WIDTH-1:0]       cfg_index,
    input  logic [d2q9me_pkg::DATA_WIDTH-1:0]          cfg_data
);
    import d2q9me_pkg::*;

    cfg_t  cfg_reg;
    item_t item;
    beat_t beat;
    mom_t  mom;
    res_t  res;
    logic  en;

    // whole pipeline advances unless a finished beat is waiting on the output
    assign en = !out_valid || out_ready;

    // configuration registers, to be written only while idle; the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_XI_SCALE:       cfg_reg.xi_scale       <= word_t'(cfg_data);
                REG_RHO_REF:        cfg_reg.rho_ref        <= word_t'(cfg_data);
                REG_INV_RHO_REF:    cfg_reg.inv_rho_ref    <= word_t'(cfg_data);
                REG_INV_RT:         cfg_reg.inv_rt         <= word_t'(cfg_data);
                REG_LAMBDA_REF:     cfg_reg.lambda_ref     <= word_t'(cfg_data);
                REG_INV_LAMBDA_REF: cfg_reg.inv_lambda_ref <= word_t'(cfg_data);
                REG_TIME_STEP:      cfg_reg.time_step      <= word_t'(cfg_data);
                default:            ;
            endcase
        end
    end

    // pack the input beat; population order follows the lattice direction index
    assign item.pops[0] = dist_0;
    assign item.pops[1] = dist_1;
    assign item.pops[2] = dist_2;
    assign item.pops[3] = dist_3;
    assign item.pops[4] = dist_4;
    assign item.pops[5] = dist_5;
    assign item.pops[6] = dist_6;
    assign item.pops[7] = dist_7;
    assign item.pops[8] = dist_8;
    assign item.force_x = force_x;
    assign item.force_y = force_y;
    assign item.face    = req_type;

    // holding register: replays the item once per direction
    d2q9me_feed u_feed (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .item     (item),
        .beat     (beat)
    );

    // moments: density sum, first moments, force term, velocity, pressure
    d2q9me_moments u_moments (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .cfg   (cfg_reg),
        .beat  (beat),
        .mom   (mom)
    );

    // equilibrium for the direction carried by each beat, plus output register
    d2q9me_equil u_equil (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .mom       (mom),
        .out_valid (out_valid),
        .res       (res)
    );

    assign direction   = res.dir;
    assign equilibrium = res.equilibrium;
    assign density     = res.density;
    assign velocity_x  = res.velocity_x;
    assign velocity_y  = res.velocity_y;
    assign pressure    = res.pressure;
    assign last        = res.last;

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the d2q9 moments and equilibrium block: a stimulus
// table of corner cells and faces, then random cells and faces under several
// register settings; every result beat is checked against pinned table values or an
// in-bench fixed-point model of the moments and the nine equilibrium values
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import d2q9me_pkg::*;

    // run shape
    localparam int RANDOM_ITEMS  = 300;
    localparam int SETTING_SPAN  = 60;      // random items per register setting
    localparam int DRAIN_CYCLES  = 40;      // idle wait for stray beats after the tail
    localparam int CYCLE_LIMIT   = 400000;

    // item kinds on req_type
    localparam logic CELL = 1'b0;
    localparam logic FACE = 1'b1;

    // fixed-point constants, rounded to nearest at the fraction width
    localparam longint Q_ONE       = longint'(1) <<< FRAC_BITS;
    localparam longint Q_MAX       = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    localparam longint Q_MIN       = -Q_MAX - 1;
    localparam longint HALF_C      = (Q_ONE + 1) / 2;
    localparam longint REST_WEIGHT = (4 * Q_ONE + 4) / 9;
    localparam longint AXIS_WEIGHT = (Q_ONE + 4) / 9;
    localparam longint DIAG_WEIGHT = (Q_ONE + 18) / 36;

    localparam word_t ZERO_W = '0;
    localparam word_t ONE_W  = word_t'(Q_ONE);

    // one stimulus row; typed rows carry their own expected values
    // (typed rows are all at rest, so both velocities are zero)
    typedef struct packed {
        item_t item;
        logic  typed;
        word_t rho;
        word_t pres;
        word_t eq_rest;
        word_t eq_axis;
        word_t eq_diag;
    } row_t;

    // random content shapes
    typedef enum logic [1:0] {
        NEAR_REST,
        FULL_RANGE,
        CORNERS,
        SCALED
    } shape_t;

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   in_valid  = 1'b0;
    logic   out_ready = 1'b0;
    item_t  stim      = '0;
    logic   cfg_wr_en = 1'b0;
    reg_idx_t cfg_index = REG_XI_SCALE;
    word_t  cfg_data  = '0;

    logic   in_ready;
    logic   out_valid;
    dir_t   direction;
    word_t  equilibrium;
    word_t  density;
    word_t  velocity_x;
    word_t  velocity_y;
    word_t  pressure;
    logic   last;

    // register copies as the block should hold them
    word_t  xi_scale_q       = CFG_RESET.xi_scale;
    word_t  rho_ref_q        = CFG_RESET.rho_ref;
    word_t  inv_rho_ref_q    = CFG_RESET.inv_rho_ref;
    word_t  inv_rt_q         = CFG_RESET.inv_rt;
    word_t  lambda_ref_q     = CFG_RESET.lambda_ref;
    word_t  inv_lambda_ref_q = CFG_RESET.inv_lambda_ref;
    word_t  time_step_q      = CFG_RESET.time_step;

    res_t   equilibria_due[$];     // beats still owed by the block, oldest first
    int     send_idle_pct = 7;
    int     recv_idle_pct = 66;
    int     mismatches    = 0;
    int     cells_sent    = 0;
    int     faces_sent    = 0;
    int     beats_checked = 0;
    int     settings_used = 1;     // reset defaults count as the first
    int     cycle_count   = 0;

    d2q9_moments_and_equilibrium u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .dist_0      (stim.pops[0]),
        .dist_1      (stim.pops[1]),
        .dist_2      (stim.pops[2]),
        .dist_3      (stim.pops[3]),
        .dist_4      (stim.pops[4]),
        .dist_5      (stim.pops[5]),
        .dist_6      (stim.pops[6]),
        .dist_7      (stim.pops[7]),
        .dist_8      (stim.pops[8]),
        .force_x     (stim.force_x),
        .force_y     (stim.force_y),
        .req_type    (stim.face),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .direction   (direction),
        .equilibrium (equilibrium),
        .density     (density),
        .velocity_x  (velocity_x),
        .velocity_y  (velocity_y),
        .pressure    (pressure),
        .last        (last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // fixed-point model
    // ------------------------------------------------------------------------

    // lattice velocity components per direction
    function automatic int step_x(input dir_t d);
        case (d)
            DIR_E, DIR_NE, DIR_SE:  return 1;
            DIR_NW, DIR_W, DIR_SW:  return -1;
            default:                return 0;
        endcase
    endfunction

    function automatic int step_y(input dir_t d);
        case (d)
            DIR_NE, DIR_N, DIR_NW:  return 1;
            DIR_SW, DIR_S, DIR_SE:  return -1;
            default:                return 0;
        endcase
    endfunction

    function automatic longint weight_of(input dir_t d);
        if (d == DIR_REST) begin
            return REST_WEIGHT;
        end
        if (step_x(d) == 0 || step_y(d) == 0) begin
            return AXIS_WEIGHT;
        end
        return DIAG_WEIGHT;
    endfunction

    function automatic longint clamp_word(input longint v);
        if (v > Q_MAX) begin
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            return Q_MIN;
        end
        return v;
    endfunction

    // exact product, magnitude rounded half away from zero, then saturated
    function automatic longint qmul(input longint a, input longint b);
        longint          p;
        longint unsigned mag;
        longint unsigned lim;
        p   = a * b;
        mag = (p < 0) ? -p : p;
        mag = (mag + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        lim = Q_MAX;
        if (p < 0) begin
            lim = lim + 1;
        end
        if (mag > lim) begin
            mag = lim;
        end
        return (p < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // moments of one item and its nine equilibrium beats
    function automatic void equilibrium_set(input item_t it);
        longint rho;
        longint sx;
        longint sy;
        longint fx;
        longint fy;
        longint ux;
        longint uy;
        longint pres;
        longint uu;
        longint e;
        longint u1;
        longint q;
        longint t;
        dir_t   d;
        res_t   r;
        rho = 0;
        sx  = 0;
        sy  = 0;
        for (int j = 0; j < NUM_DIR; j++) begin
            d   = dir_t'(j);
            rho = rho + it.pops[j];
            sx  = sx + step_x(d) * longint'(it.pops[j]);
            sy  = sy + step_y(d) * longint'(it.pops[j]);
        end
        rho = clamp_word(rho);
        sx  = clamp_word(sx);
        sy  = clamp_word(sy);

        // faces take half the force step
        fx = qmul(time_step_q, it.force_x);
        fy = qmul(time_step_q, it.force_y);
        if (it.face == FACE) begin
            fx = qmul(fx, HALF_C);
            fy = qmul(fy, HALF_C);
        end
        ux   = qmul(clamp_word(qmul(xi_scale_q, sx) + fx), inv_rho_ref_q);
        uy   = qmul(clamp_word(qmul(xi_scale_q, sy) + fy), inv_rho_ref_q);
        pres = qmul(qmul(HALF_C, clamp_word(rho - rho_ref_q)), inv_lambda_ref_q);
        uu   = clamp_word(qmul(ux, ux) + qmul(uy, uy));

        for (int j = 0; j < NUM_DIR; j++) begin
            d  = dir_t'(j);
            e  = clamp_word(step_x(d) * ux + step_y(d) * uy);
            u1 = qmul(qmul(xi_scale_q, e), inv_rt_q);
            q  = clamp_word(u1 + qmul(HALF_C, qmul(u1, u1)) - qmul(uu, lambda_ref_q));
            t  = clamp_word(rho + qmul(rho_ref_q, q));
            r.dir         = d;
            r.equilibrium = word_t'(qmul(weight_of(d), t));
            r.density     = word_t'(rho);
            r.velocity_x  = word_t'(ux);
            r.velocity_y  = word_t'(uy);
            r.pressure    = word_t'(pres);
            r.last        = (d == DIR_LAST);
            equilibria_due.push_back(r);
        end
    endfunction

    // beats of a typed row, taken straight from the table
    function automatic void typed_set(input row_t row);
        res_t r;
        dir_t d;
        for (int j = 0; j < NUM_DIR; j++) begin
            d = dir_t'(j);
            r.dir = d;
            if (d == DIR_REST) begin
                r.equilibrium = row.eq_rest;
            end else if (weight_of(d) == AXIS_WEIGHT) begin
                r.equilibrium = row.eq_axis;
            end else begin
                r.equilibrium = row.eq_diag;
            end
            r.density    = row.rho;
            r.velocity_x = '0;
            r.velocity_y = '0;
            r.pressure   = row.pres;
            r.last       = (d == DIR_LAST);
            equilibria_due.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic row_t mk_row(input word_t [NUM_DIR-1:0] d, input word_t fx,
                                    input word_t fy, input logic kind);
        row_t r;
        r = '0;
        r.item.pops    = d;
        r.item.force_x = fx;
        r.item.force_y = fy;
        r.item.face    = kind;
        return r;
    endfunction

    function automatic row_t pinned(input row_t r, input word_t rho, input word_t pres,
                                    input word_t er, input word_t ea, input word_t ed);
        r.typed   = 1'b1;
        r.rho     = rho;
        r.pres    = pres;
        r.eq_rest = er;
        r.eq_axis = ea;
        r.eq_diag = ed;
        return r;
    endfunction

    function automatic word_t rand_word(input shape_t shape, input longint centre);
        word_t v;
        case (shape)
            // small spread around a resting population
            NEAR_REST:  return word_t'(centre + longint'($urandom_range(4194304)) - 2097152);
            FULL_RANGE: return $urandom;
            CORNERS: begin
                case ($urandom_range(3))
                    0:       return WORD_MAX;
                    1:       return WORD_MIN;
                    2:       return ZERO_W;
                    default: return $urandom;
                endcase
            end
            default: begin
                v = $urandom >> $urandom_range(31);
                return $urandom_range(1) ? -v : v;
            end
        endcase
    endfunction

    function automatic item_t rand_item();
        item_t  it;
        shape_t shape;
        int     pick;
        pick  = $urandom_range(9);
        shape = (pick < 6) ? NEAR_REST : (pick < 8) ? FULL_RANGE
              : (pick < 9) ? CORNERS : SCALED;
        for (int j = 0; j < NUM_DIR; j++) begin
            it.pops[j] = rand_word(shape, weight_of(dir_t'(j)));
        end
        it.force_x = rand_word(shape, 0);
        it.force_y = rand_word(shape, 0);
        it.face    = 1'($urandom_range(1));
        return it;
    endfunction

    // all tasks start and end just after a falling edge

    task automatic push_item(input row_t r);
        // sender gaps
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        stim     = r.item;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        // beat taken; book its results away from the rising edge
        @(negedge clk);
        if (r.typed) begin
            typed_set(r);
        end else begin
            equilibrium_set(r.item);
        end
        if (r.item.face == FACE) begin
            faces_sent++;
        end else begin
            cells_sent++;
        end
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (equilibria_due.size() != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input reg_idx_t idx, input word_t v);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_XI_SCALE:       xi_scale_q       = v;
            REG_RHO_REF:        rho_ref_q        = v;
            REG_INV_RHO_REF:    inv_rho_ref_q    = v;
            REG_INV_RT:         inv_rt_q         = v;
            REG_LAMBDA_REF:     lambda_ref_q     = v;
            REG_INV_LAMBDA_REF: inv_lambda_ref_q = v;
            REG_TIME_STEP:      time_step_q      = v;
            default: ;
        endcase
    endtask

    task automatic load_setting(input word_t xi, input word_t rho, input word_t irho,
                                input word_t irt, input word_t lam, input word_t ilam,
                                input word_t ts);
        write_reg(REG_XI_SCALE, xi);
        write_reg(REG_RHO_REF, rho);
        write_reg(REG_INV_RHO_REF, irho);
        write_reg(REG_INV_RT, irt);
        write_reg(REG_LAMBDA_REF, lam);
        write_reg(REG_INV_LAMBDA_REF, ilam);
        write_reg(REG_TIME_STEP, ts);
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // result side: random back-pressure and the beat checker
    // ------------------------------------------------------------------------

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void field_check(input string what, input longint want,
                                        input longint got);
        if (want != got) begin
            mismatches++;
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge clk) begin
        res_t want;
        if (rst_n && out_valid && out_ready) begin
            beats_checked++;
            if (equilibria_due.size() == 0) begin
                mismatches++;
                $display("%0t result beat for direction %0d with nothing outstanding",
                         $time, direction);
            end else begin
                want = equilibria_due.pop_front();
                field_check("direction",   want.dir,         direction);
                field_check("equilibrium", want.equilibrium, equilibrium);
                field_check("density",     want.density,     density);
                field_check("velocity_x",  want.velocity_x,  velocity_x);
                field_check("velocity_y",  want.velocity_y,  velocity_y);
                field_check("pressure",    want.pressure,    pressure);
                field_check("last",        want.last,        last);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d beats outstanding",
                     cycle_count, equilibria_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial begin
        row_t directed_rows[$];
        row_t r;
        word_t [NUM_DIR-1:0] at_rest;
        word_t [NUM_DIR-1:0] drifting;

        // unit density at rest, and a gentle eastward drift
        at_rest  = {{(NUM_DIR-1){ZERO_W}}, ONE_W};
        drifting = {word_t'(DIAG_WEIGHT), word_t'(AXIS_WEIGHT), word_t'(DIAG_WEIGHT),
                    word_t'(AXIS_WEIGHT), word_t'(DIAG_WEIGHT), word_t'(AXIS_WEIGHT),
                    word_t'(DIAG_WEIGHT), word_t'(AXIS_WEIGHT + 1048576),
                    word_t'(REST_WEIGHT)};

        // population vectors are written from direction 8 down to direction 0
        // empty cell: zero moments, pressure -0.5 * 2/3 under the defaults
        directed_rows.push_back(pinned(mk_row({NUM_DIR{ZERO_W}}, ZERO_W, ZERO_W, CELL),
                                       ZERO_W, -32'sd5592406, ZERO_W, ZERO_W, ZERO_W));
        // unit density at rest: the equilibria are the bare lattice weights
        directed_rows.push_back(pinned(mk_row(at_rest, ZERO_W, ZERO_W, CELL),
                                       ONE_W, ZERO_W, 32'sd7456540, 32'sd1864135,
                                       32'sd466034));
        directed_rows.push_back(pinned(mk_row(at_rest, ZERO_W, ZERO_W, FACE),
                                       ONE_W, ZERO_W, 32'sd7456540, 32'sd1864135,
                                       32'sd466034));
        // density sum saturating high and low
        directed_rows.push_back(mk_row({NUM_DIR{WORD_MAX}}, ZERO_W, ZERO_W, CELL));
        directed_rows.push_back(mk_row({NUM_DIR{WORD_MIN}}, ZERO_W, ZERO_W, FACE));
        // one or two streaming directions driving the velocity into saturation
        directed_rows.push_back(mk_row({{7{ZERO_W}}, WORD_MAX, ZERO_W}, ZERO_W, ZERO_W,
                                       CELL));
        directed_rows.push_back(mk_row({{3{ZERO_W}}, WORD_MIN, {5{ZERO_W}}}, ZERO_W,
                                       ZERO_W, FACE));
        directed_rows.push_back(mk_row({ZERO_W, WORD_MIN, {3{ZERO_W}}, WORD_MAX,
                                        {3{ZERO_W}}}, ZERO_W, ZERO_W, CELL));
        // force extremes, cell and face
        directed_rows.push_back(mk_row(at_rest, WORD_MAX, WORD_MIN, CELL));
        directed_rows.push_back(mk_row(at_rest, WORD_MIN, WORD_MAX, FACE));
        // face halving: odd force and a one-lsb force, ties away from zero
        directed_rows.push_back(mk_row(at_rest, word_t'(-Q_ONE), word_t'(Q_ONE / 2 + 1),
                                       FACE));
        directed_rows.push_back(mk_row(at_rest, -32'sd1, 32'sd1, FACE));
        // alternating bit patterns and all ones
        directed_rows.push_back(mk_row({NUM_DIR{32'h5555_5555}}, 32'hAAAA_AAAA,
                                       32'h5555_5555, CELL));
        directed_rows.push_back(mk_row({NUM_DIR{32'hAAAA_AAAA}}, 32'h5555_5555,
                                       32'hAAAA_AAAA, FACE));
        directed_rows.push_back(mk_row({NUM_DIR{32'hFFFF_FFFF}}, -32'sd1, -32'sd1, FACE));
        // physical flow with a small force, both kinds
        directed_rows.push_back(mk_row(drifting, 32'sd1048576, -32'sd1048576, CELL));
        directed_rows.push_back(mk_row(drifting, 32'sd1048576, -32'sd1048576, FACE));

        // reset held, then released on a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // table rows under the reset defaults
        foreach (directed_rows[i]) begin
            push_item(directed_rows[i]);
        end

        // random part: five register settings, three back-pressure patterns
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % SETTING_SPAN == 0) begin
                settle();
                case (n / SETTING_SPAN)
                    // sound-speed scale, denser reference, half force step
                    0: load_setting(32'sd29058991, 32'sd20971520, 32'sd13421773,
                                    32'sd5592405, 32'sd25165824, 32'sd11184811,
                                    32'sd8388608);
                    1: load_setting(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                                    WORD_MAX, WORD_MAX);
                    2: load_setting(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                                    WORD_MIN, WORD_MIN);
                    3: load_setting($urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom);
                    // sign flips and a zero reference density
                    default: load_setting(word_t'(-Q_ONE), ZERO_W, word_t'(4 * Q_ONE),
                                          ONE_W, word_t'(-Q_ONE), word_t'(-Q_ONE / 2),
                                          word_t'(-2 * Q_ONE));
                endcase
            end
            if (n == 100) begin
                send_idle_pct = 66;
                recv_idle_pct = 7;
            end
            if (n == 200) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // sender holds off until every owed beat is back
            if (n % 100 == 50) begin
                settle();
            end
            r      = '0;
            r.item = rand_item();
            push_item(r);
        end

        // wait out the tail and watch for stray beats
        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d cells and %0d faces under %0d register settings",
                 cells_sent, faces_sent, settings_used);
        $display("%0d result beats checked with both sides stalling in turn, then flat out",
                 beats_checked);
        if (mismatches == 0 && equilibria_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
